/* sv/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg: shared constants and types
// Widths, fixed-point constants and divider control structs for the
// windowed position smoother.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int WINDOW   = 16;
  localparam int POS_W    = 16;
  localparam int ALPHA_W  = 17;
  localparam int FRAC_W   = 16;
  localparam int RMS_W    = 17;
  localparam int FILL_W   = 5;

  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int TW_MAX   = WINDOW * (WINDOW + 1) / 2;
  localparam int TW_W     = $clog2(TW_MAX + 1);

  localparam int SUM_W    = POS_W + CNT_W;
  localparam int WSUM_W   = POS_W + TW_W + 1;
  localparam int SQ_W     = 2 * POS_W + CNT_W;
  localparam int Q_W      = SQ_W + CNT_W + 2;
  localparam int ACC_W    = POS_W + FRAC_W + 1;

  localparam int MA_MIN   = (RMS_W + 2 > 2 * CNT_W + 1) ? RMS_W + 2 : 2 * CNT_W + 1;
  localparam int MA_W     = (SUM_W > MA_MIN) ? SUM_W : MA_MIN;
  localparam int MB_W     = SQ_W + 1;
  localparam int MP_W     = MA_W + MB_W;

  localparam int DVD_W    = (WSUM_W > SUM_W) ? WSUM_W : SUM_W;
  localparam int DEN_W    = TW_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << FRAC_W);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1 << (FRAC_W - 1));

  typedef struct packed {
    logic                     start;
    logic signed [DVD_W-1:0]  num;
    logic        [DEN_W-1:0]  den;
  } div_cmd_t;

  typedef struct packed {
    logic                     done;
    logic signed [DVD_W-1:0]  quot;
  } div_stat_t;

endpackage

/* sv/wps_stream_if.sv */
// ----------------------------------------------------------------------------
// wps_stream_if: request and result channels
// Valid/ready channels carrying one position request and one result.
// ----------------------------------------------------------------------------
interface wps_pos_if;
  logic                              valid;
  logic                              ready;
  logic signed [wps_pkg::POS_W-1:0]  pos_x;
  logic signed [wps_pkg::POS_W-1:0]  pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface wps_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [wps_pkg::POS_W-1:0]  mean_x;
  logic signed [wps_pkg::POS_W-1:0]  mean_y;
  logic signed [wps_pkg::POS_W-1:0]  weighted_x;
  logic signed [wps_pkg::POS_W-1:0]  weighted_y;
  logic signed [wps_pkg::POS_W-1:0]  smooth_x;
  logic signed [wps_pkg::POS_W-1:0]  smooth_y;
  logic        [wps_pkg::RMS_W-1:0]  rms_spread;
  logic        [wps_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, output mean_x, output mean_y, output weighted_x,
                  output weighted_y, output smooth_x, output smooth_y,
                  output rms_spread, output fill_count, input ready);
  modport sink   (input valid, input mean_x, input mean_y, input weighted_x,
                  input weighted_y, input smooth_x, input smooth_y,
                  input rms_spread, input fill_count, output ready);
endinterface

/* sv/windowed_position_smoother.sv */
// ----------------------------------------------------------------------------
// windowed_position_smoother: sliding-window statistics over 2D positions
// Keeps the last WINDOW positions and, per request, returns plain mean,
// linearly weighted mean, exponential smoothing and RMS spread.
// ----------------------------------------------------------------------------
// One request at a time. A request walks the n held entries, n being the
// fill count after the push (at most 16, a full window). In the window
// walk one shared multiplier does squares, weights and both smoothing
// steps in turn for each held entry; variance setup follows, then a
// bitwise root over 17 bits and four rounding divisions through a
// one-bit-per-cycle divider. ready is high only while no request is in
// progress; a finished result waits in the output register and the next
// request can be taken meanwhile.
// smoothing_alpha is written whenever smoothing_alpha_we is high; values
// above 65536 act as 1.0. Window storage sits in one RAM, x and y side by
// side, and needs no clearing since only held entries are read.
// ----------------------------------------------------------------------------
module windowed_position_smoother (
  input  logic                          clk,
  input  logic                          rst,
  wps_pos_if.sink                       pos_req,
  wps_res_if.source                     result,
  input  logic                          smoothing_alpha_we,
  input  logic [wps_pkg::ALPHA_W-1:0]   smoothing_alpha
);
  import wps_pkg::*;

  localparam int QS_W  = Q_W + 1;
  localparam int T_W   = CNT_W + 1;
  localparam int BIT_W = $clog2(RMS_W);
  localparam int HALF_Q16 = 1 << (FRAC_W - 1);

  // walk steps, one entry per pass
  localparam logic [3:0] W_ADDR  = 4'd0;
  localparam logic [3:0] W_LOAD  = 4'd1;
  localparam logic [3:0] W_SQX   = 4'd2;
  localparam logic [3:0] W_SQY   = 4'd3;
  localparam logic [3:0] W_WX    = 4'd4;
  localparam logic [3:0] W_WY    = 4'd5;
  localparam logic [3:0] W_DECX  = 4'd6;
  localparam logic [3:0] W_NEWX  = 4'd7;
  localparam logic [3:0] W_DECY  = 4'd8;
  localparam logic [3:0] W_NEWY  = 4'd9;
  localparam logic [3:0] W_END   = 4'd10;
  // variance setup steps
  localparam logic [3:0] P_NSQ   = 4'd0;
  localparam logic [3:0] P_SXX   = 4'd1;
  localparam logic [3:0] P_SYY   = 4'd2;
  localparam logic [3:0] P_NN    = 4'd3;
  localparam logic [3:0] P_END   = 4'd4;
  // root steps
  localparam logic [3:0] R_UU    = 4'd0;
  localparam logic [3:0] R_SCALE = 4'd1;
  localparam logic [3:0] R_TEST  = 4'd2;
  // divide steps
  localparam logic [3:0] D_GO    = 4'd0;
  localparam logic [3:0] D_WAIT  = 4'd1;

  localparam logic [1:0] DV_MX = 2'd0;
  localparam logic [1:0] DV_MY = 2'd1;
  localparam logic [1:0] DV_WX = 2'd2;
  localparam logic [1:0] DV_WY = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WALK   = 6'b000010,
    S_POST   = 6'b000100,
    S_ROOT   = 6'b001000,
    S_DIVIDE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [MP_W-1:0] p);
    logic [MP_W-1:0]          m;
    logic [MP_W-1:0]          r;
    logic signed [ACC_W-1:0]  rs;
    m  = p[MP_W-1] ? MP_W'(-p) : MP_W'(p);
    r  = (m + MP_W'(HALF_Q16)) >> FRAC_W;
    rs = ACC_W'(r);
    return p[MP_W-1] ? -rs : rs;
  endfunction

  state_t                    state;
  logic [3:0]                step;
  logic [ALPHA_W-1:0]        alpha_r;
  logic [IDX_W-1:0]          write_slot;
  logic [CNT_W-1:0]          entries_held;
  logic [IDX_W-1:0]          rd_addr;
  logic [CNT_W-1:0]          idx;
  logic signed [POS_W-1:0]   vx, vy;
  logic signed [SUM_W-1:0]   sx, sy;
  logic signed [WSUM_W-1:0]  wx, wy;
  logic [TW_W-1:0]           tw;
  logic [SQ_W-1:0]           sq;
  logic signed [ACC_W-1:0]   accx, accy, tmpx, tmpy;
  logic signed [QS_W-1:0]    q;
  logic [2*CNT_W-1:0]        nsq;
  logic [RMS_W-1:0]          root_r;
  logic [BIT_W-1:0]          bitn;
  logic [1:0]                div_sel;
  logic signed [POS_W-1:0]   res_mx, res_my, res_wx, res_wy;

  logic                      accept;
  logic [IDX_W-1:0]          ws_next;
  logic [CNT_W-1:0]          held_next;
  logic [T_W-1:0]            first_t;
  logic [IDX_W-1:0]          first;
  logic [IDX_W-1:0]          rd_addr_inc;
  logic [CNT_W-1:0]          idx_inc;
  logic [ALPHA_W-1:0]        alpha_eff, beta;
  logic [RMS_W-1:0]          cand;
  logic [RMS_W:0]            u;
  logic                      emit_go;

  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [MP_W-1:0]    mp;

  logic [2*POS_W-1:0]        ram_rdata;
  div_cmd_t                  div_cmd;
  div_stat_t                 div_stat;

  assign pos_req.ready = (state == S_IDLE);
  assign accept        = pos_req.valid && pos_req.ready;
  assign emit_go       = (state == S_EMIT) && (!result.valid || result.ready);

  // slot bookkeeping for the push
  always_comb begin
    ws_next   = (write_slot == IDX_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
    held_next = (entries_held < CNT_W'(WINDOW)) ? entries_held + 1'b1 : entries_held;
    first_t   = T_W'(ws_next) + T_W'(WINDOW) - T_W'(held_next);
    first     = (first_t >= T_W'(WINDOW)) ? IDX_W'(first_t - T_W'(WINDOW))
                                           : IDX_W'(first_t);
    rd_addr_inc = (rd_addr == IDX_W'(WINDOW - 1)) ? '0 : rd_addr + 1'b1;
    idx_inc     = idx + 1'b1;
    alpha_eff   = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    beta        = ALPHA_ONE - alpha_eff;
    cand        = root_r | (RMS_W'(1) << bitn);
    u           = {cand, 1'b0} - (RMS_W+1)'(1);
  end

  wps_ram #(.WIDTH(2 * POS_W), .DEPTH(WINDOW)) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (write_slot),
    .wdata ({pos_req.pos_x, pos_req.pos_y}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_WALK: begin
        unique case (step)
          W_SQX:  begin ma = MA_W'(vx);        mb = MB_W'(vx);   end
          W_SQY:  begin ma = MA_W'(vy);        mb = MB_W'(vy);   end
          W_WX:   begin ma = MA_W'(idx_inc);   mb = MB_W'(vx);   end
          W_WY:   begin ma = MA_W'(idx_inc);   mb = MB_W'(vy);   end
          W_DECX: begin ma = MA_W'(beta);      mb = MB_W'(accx); end
          W_NEWX: begin ma = MA_W'(alpha_eff); mb = MB_W'(vx);   end
          W_DECY: begin ma = MA_W'(beta);      mb = MB_W'(accy); end
          W_NEWY: begin ma = MA_W'(alpha_eff); mb = MB_W'(vy);   end
          default: ;
        endcase
      end
      S_POST: begin
        unique case (step)
          P_NSQ: begin ma = MA_W'(entries_held); mb = MB_W'(sq); end
          P_SXX: begin ma = MA_W'(sx);           mb = MB_W'(sx); end
          P_SYY: begin ma = MA_W'(sy);           mb = MB_W'(sy); end
          P_NN:  begin ma = MA_W'(entries_held); mb = MB_W'(entries_held); end
          default: ;
        endcase
      end
      S_ROOT: begin
        unique case (step)
          R_UU:    begin ma = MA_W'(u);   mb = MB_W'(u);  end
          R_SCALE: begin ma = MA_W'(nsq); mb = MB_W'(mp); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  wps_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (mp)
  );

  always_comb begin
    div_cmd.start = (state == S_DIVIDE) && (step == D_GO);
    unique case (div_sel)
      DV_MX: begin div_cmd.num = DVD_W'(sx); div_cmd.den = DEN_W'(entries_held); end
      DV_MY: begin div_cmd.num = DVD_W'(sy); div_cmd.den = DEN_W'(entries_held); end
      DV_WX: begin div_cmd.num = DVD_W'(wx); div_cmd.den = tw; end
      DV_WY: begin div_cmd.num = DVD_W'(wy); div_cmd.den = tw; end
      default: begin div_cmd.num = '0; div_cmd.den = '0; end
    endcase
  end

  wps_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .stat (div_stat)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_r <= ALPHA_RESET;
    end else if (smoothing_alpha_we) begin
      alpha_r <= smoothing_alpha;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      write_slot   <= '0;
      entries_held <= '0;
      div_sel      <= DV_MX;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            write_slot   <= ws_next;
            entries_held <= held_next;
            rd_addr      <= first;
            idx          <= '0;
            sx   <= '0;
            sy   <= '0;
            wx   <= '0;
            wy   <= '0;
            sq   <= '0;
            tw   <= '0;
            step <= W_ADDR;
            state <= S_WALK;
          end
        end

        S_WALK: begin
          step <= step + 1'b1;
          unique case (step)
            W_ADDR: ;   // RAM read of the current entry in flight
            W_LOAD: begin
              vx <= ram_rdata[2*POS_W-1:POS_W];
              vy <= ram_rdata[POS_W-1:0];
              sx <= sx + SUM_W'($signed(ram_rdata[2*POS_W-1:POS_W]));
              sy <= sy + SUM_W'($signed(ram_rdata[POS_W-1:0]));
              tw <= tw + TW_W'(idx_inc);
            end
            W_SQX: ;
            W_SQY:  sq <= sq + SQ_W'(mp);
            W_WX:   sq <= sq + SQ_W'(mp);
            W_WY:   wx <= wx + WSUM_W'(mp);
            W_DECX: wy <= wy + WSUM_W'(mp);
            W_NEWX: tmpx <= rnd16(mp);
            W_DECY: begin
              // oldest entry seeds the smoothing
              accx <= (idx == '0) ? (ACC_W'(vx) <<< FRAC_W) : ACC_W'(mp) + tmpx;
            end
            W_NEWY: tmpy <= rnd16(mp);
            W_END: begin
              accy    <= (idx == '0) ? (ACC_W'(vy) <<< FRAC_W) : ACC_W'(mp) + tmpy;
              idx     <= idx_inc;
              rd_addr <= rd_addr_inc;
              if (idx_inc == entries_held) begin
                step  <= P_NSQ;
                state <= S_POST;
              end else begin
                step <= W_ADDR;
              end
            end
            default: step <= W_ADDR;
          endcase
        end

        S_POST: begin
          step <= step + 1'b1;
          unique case (step)
            P_NSQ: ;
            P_SXX: q <= QS_W'(mp);
            P_SYY: q <= q - QS_W'(mp);
            P_NN:  q <= q - QS_W'(mp);
            P_END: begin
              nsq    <= (2*CNT_W)'(mp);
              q      <= q <<< 2;   // 4 * n^2 * variance
              root_r <= '0;
              bitn   <= BIT_W'(RMS_W - 1);
              step   <= R_UU;
              state  <= S_ROOT;
            end
            default: step <= P_NSQ;
          endcase
        end

        // bitwise search: keep bit if ((2r-1) n)^2 <= 4 n^2 var
        S_ROOT: begin
          step <= step + 1'b1;
          unique case (step)
            R_UU:    ;
            R_SCALE: ;
            R_TEST: begin
              if (mp <= MP_W'(q)) begin
                root_r <= cand;
              end
              step <= R_UU;
              if (bitn == '0) begin
                div_sel <= DV_MX;
                step    <= D_GO;
                state   <= S_DIVIDE;
              end else begin
                bitn <= bitn - 1'b1;
              end
            end
            default: step <= R_UU;
          endcase
        end

        S_DIVIDE: begin
          unique case (step)
            D_GO: step <= D_WAIT;
            D_WAIT: begin
              if (div_stat.done) begin
                unique case (div_sel)
                  DV_MX: res_mx <= POS_W'(div_stat.quot);
                  DV_MY: res_my <= POS_W'(div_stat.quot);
                  DV_WX: res_wx <= POS_W'(div_stat.quot);
                  DV_WY: res_wy <= POS_W'(div_stat.quot);
                  default: ;
                endcase
                step <= D_GO;
                if (div_sel == DV_WY) begin
                  state <= S_EMIT;
                end else begin
                  div_sel <= div_sel + 1'b1;
                end
              end
            end
            default: step <= D_GO;
          endcase
        end

        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      result.mean_x     <= res_mx;
      result.mean_y     <= res_my;
      result.weighted_x <= res_wx;
      result.weighted_y <= res_wy;
      result.smooth_x   <= POS_W'(rnd16(MP_W'(accx)));
      result.smooth_y   <= POS_W'(rnd16(MP_W'(accy)));
      result.rms_spread <= root_r;
      result.fill_count <= FILL_W'(entries_held);
    end
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> !pos_req.ready) else $error("request accepted while busy");
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    entries_held <= CNT_W'(WINDOW)) else $error("fill count beyond window");
  a_var_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> !q[QS_W-1]) else $error("negative variance term");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> result.valid) else $error("result lost at emit");

endmodule

/* sv/wps_ram.sv */
// ----------------------------------------------------------------------------
// wps_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/wps_mul.sv */
// ----------------------------------------------------------------------------
// wps_mul: shared signed multiplier
// Single signed multiply with a registered product.
// ----------------------------------------------------------------------------
module wps_mul (
  input  logic                             clk,
  input  logic signed [wps_pkg::MA_W-1:0]  a,
  input  logic signed [wps_pkg::MB_W-1:0]  b,
  output logic signed [wps_pkg::MP_W-1:0]  p
);
  import wps_pkg::*;

  always_ff @(posedge clk) begin
    p <= MP_W'(a) * MP_W'(b);
  end

endmodule

/* sv/wps_div.sv */
// ----------------------------------------------------------------------------
// wps_div: iterative rounding divider
// Signed dividend over positive divisor, round half away from zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wps_div (
  input  logic                  clk,
  input  logic                  rst,
  input  wps_pkg::div_cmd_t     cmd,
  output wps_pkg::div_stat_t    stat
);
  import wps_pkg::*;

  localparam int MAG_W = DVD_W + 1;
  localparam int DC_W  = $clog2(MAG_W + 1);

  logic              busy;
  logic [DC_W-1:0]   cnt;
  logic [MAG_W-1:0]  mag;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic              neg;

  logic [MAG_W-1:0]  abs_num;
  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [MAG_W-1:0]  mag_next;
  logic [DEN_W-1:0]  rem_next;

  always_comb begin
    abs_num  = cmd.num[DVD_W-1] ? MAG_W'(-MAG_W'(cmd.num)) : MAG_W'(cmd.num);
    trial    = {rem, mag[MAG_W-1]};
    qbit     = (trial >= (DEN_W+1)'(den_r));
    rem_next = qbit ? DEN_W'(trial - (DEN_W+1)'(den_r)) : DEN_W'(trial);
    mag_next = {mag[MAG_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        cnt   <= DC_W'(MAG_W);
        neg   <= cmd.num[DVD_W-1];
        mag   <= abs_num + MAG_W'(cmd.den >> 1);
        rem   <= '0;
        den_r <= cmd.den;
      end else if (busy) begin
        mag <= mag_next;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == DC_W'(1)) begin
          busy      <= 1'b0;
          stat.done <= 1'b1;
          stat.quot <= neg ? -DVD_W'(mag_next) : DVD_W'(mag_next);
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !busy) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !stat.done) else $error("divider done held");

endmodule
